>>> rtl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared sizes, operation and status codes, and the entry type of the cells.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int QUEUE_DEPTH = 1024;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 32;
    localparam int OCOUNT_W = 11;

    localparam int IN_DATA_W  = ((MODE_W + 2 * VALUE_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((STATUS_W + 2 * VALUE_W + 1 + OCOUNT_W + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_QUERY  = 2'd2
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [VALUE_W-1:0] pri;
        logic signed [VALUE_W-1:0] data;
    } t_entry;

    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctrl;

endpackage

>>> rtl/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one slot of the sorted row and shifts toward its neighbors.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic                             i_clk,
    input  spq_pkg::t_cell_ctrl              i_ctrl,
    input  spq_pkg::t_entry                  i_new,
    input  logic [spq_pkg::COUNT_W-1:0]      i_index,
    input  logic [spq_pkg::COUNT_W-1:0]      i_count,
    input  logic                             i_prev_hold,
    input  spq_pkg::t_entry                  i_prev_entry,
    input  spq_pkg::t_entry                  i_next_entry,
    output spq_pkg::t_entry                  o_entry,
    output logic                             o_hold
);

    spq_pkg::t_entry r_entry;
    logic            live;

    // A live slot whose priority is at least the new one stays in place.
    assign live   = i_index < i_count;
    assign o_hold = live && (r_entry.pri >= i_new.pri);
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins) begin
            if (!o_hold) begin
                r_entry <= i_prev_hold ? i_new : i_prev_entry;
            end
        end else if (i_ctrl.del) begin
            r_entry <= i_next_entry;
        end
    end

endmodule

>>> rtl/sorted_priority_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// A priority queue kept as a row of cells sorted by priority, highest first.
// ----------------------------------------------------------------------------
// Usage:
//   Each word on the slave stream is one operation: insert a data/priority
//   pair, delete the highest-priority entry, or query the fill state.
//   Each accepted word produces exactly one result word on the master stream
//   carrying a status, the removed entry (zero unless a delete succeeded),
//   an empty flag and the live entry count after the operation.
//   Every cell compares its priority with the incoming one and shifts toward
//   its neighbor in the same cycle, so the whole row is updated at once: the
//   result is registered and appears in the cycle after acceptance, and the
//   unit takes one word per cycle as long as the receiver keeps up.
//   The result sits in an output register; a new word is accepted while the
//   register is empty or being taken in the same cycle. When the receiver
//   stalls, the result holds and the slave side stops taking words.
//   Reset empties the queue (count to zero) and drops any pending result.
//   Slot contents are not cleared; only live slots are ever read.
//   Insert on a full queue reports full; delete on an empty one reports empty.
//   Equal priorities are served in arrival order.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // tdata: mode[1:0], item_data[33:2], item_priority[65:34], zero pad
    input  logic [spq_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // tdata: status[1:0], removed_data[33:2], removed_priority[65:34],
    //        is_empty[66], entry_count[77:67], zero pad
    output logic [spq_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata
);

    localparam int DEPTH = spq_pkg::QUEUE_DEPTH;
    localparam int CW    = spq_pkg::COUNT_W;
    localparam int VW    = spq_pkg::VALUE_W;

    // Input word fields.
    logic [spq_pkg::MODE_W-1:0] in_mode;
    spq_pkg::t_entry            in_entry;

    assign in_mode       = i_s_axis_tdata[spq_pkg::MODE_W-1:0];
    assign in_entry.data = i_s_axis_tdata[spq_pkg::MODE_W +: VW];
    assign in_entry.pri  = i_s_axis_tdata[spq_pkg::MODE_W + VW +: VW];

    // Control and state.
    logic                    accept;
    logic                    full;
    logic                    empty;
    spq_pkg::t_cell_ctrl     ctrl;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic                    r_out_valid;
    logic                    n_out_valid;
    spq_pkg::t_status        n_status;
    spq_pkg::t_entry         n_removed;
    spq_pkg::t_status        r_status;
    spq_pkg::t_entry         r_removed;
    logic [CW-1:0]           r_out_count;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign full            = r_count == CW'(DEPTH);
    assign empty           = r_count == '0;

    // Cell row: each cell sees its left neighbor's hold flag and both
    // neighbors' entries; cell 0 always takes a new entry it does not keep.
    spq_pkg::t_entry cell_entry [DEPTH];
    logic            cell_hold  [DEPTH];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            spq_pkg::t_entry prev_entry;
            spq_pkg::t_entry next_entry;
            logic            prev_hold;

            if (g == 0) begin : g_first
                assign prev_entry = in_entry;
                assign prev_hold  = 1'b1;
            end else begin : g_mid
                assign prev_entry = cell_entry[g-1];
                assign prev_hold  = cell_hold[g-1];
            end

            if (g == DEPTH - 1) begin : g_last
                assign next_entry = cell_entry[g];
            end else begin : g_inner
                assign next_entry = cell_entry[g+1];
            end

            spq_cell u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (ctrl),
                .i_new        (in_entry),
                .i_index      (CW'(g)),
                .i_count      (r_count),
                .i_prev_hold  (prev_hold),
                .i_prev_entry (prev_entry),
                .i_next_entry (next_entry),
                .o_entry      (cell_entry[g]),
                .o_hold       (cell_hold[g])
            );
        end
    endgenerate

    // Decode the operation and its result.
    always_comb begin
        ctrl      = '0;
        n_count   = r_count;
        n_status  = spq_pkg::ST_OK;
        n_removed = '0;
        if (accept) begin
            case (in_mode)
                spq_pkg::MODE_INSERT: begin
                    if (full) begin
                        n_status = spq_pkg::ST_FULL;
                    end else begin
                        ctrl.ins = 1'b1;
                        n_count  = r_count + CW'(1);
                    end
                end
                spq_pkg::MODE_DELETE: begin
                    if (empty) begin
                        n_status = spq_pkg::ST_EMPTY;
                    end else begin
                        ctrl.del  = 1'b1;
                        n_count   = r_count - CW'(1);
                        n_removed = cell_entry[0];
                    end
                end
                default: begin
                    n_status = spq_pkg::ST_OK;
                end
            endcase
        end
    end

    assign n_out_valid = accept || (r_out_valid && !i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= n_status;
            r_removed   <= n_removed;
            r_out_count <= n_count;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = spq_pkg::OUT_DATA_W'({
        spq_pkg::OCOUNT_W'(r_out_count),
        r_out_count == '0,
        r_removed.pri,
        r_removed.data,
        r_status
    });

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("live count above queue depth");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && in_mode == spq_pkg::MODE_INSERT && !full
        |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow the queue");

    a_empty_delete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && in_mode == spq_pkg::MODE_DELETE && empty
        |=> o_m_axis_tvalid && r_status == spq_pkg::ST_EMPTY && r_count == '0)
        else $error("delete on empty queue misreported");

    a_removed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && in_mode != spq_pkg::MODE_DELETE |=> r_removed == '0)
        else $error("removed entry nonzero without a delete");
`endif

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue unit testbench
// Drives insert, delete and query words into the unit and checks every result
// word against a literal reply or an in-bench model of the sorted queue. A
// short table of directed words covers extremes, equal priorities, the unused
// mode and the empty cases. Random traffic then fills the queue past full and
// turns to draining it, under three stall patterns, the last with no stalls.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int VW = spq_pkg::VALUE_W;
    localparam int MW = spq_pkg::MODE_W;
    localparam logic [MW-1:0] MODE_SPARE = 2'd3;
    localparam int RANDOM_WORDS = 1750;
    localparam int DIRECTED_ROWS = 25;
    localparam int DRAIN_CYCLES = 8;
    localparam int EDGE_DWELL = 16;

    typedef struct packed {
        logic [spq_pkg::STATUS_W-1:0] status;
        logic signed [VW-1:0]         rdata;
        logic signed [VW-1:0]         rpri;
        logic                         empty;
        logic [spq_pkg::OCOUNT_W-1:0] count;
    } t_queue_reply;

    // A row either carries a literal reply or leaves it to the queue model.
    typedef struct packed {
        logic [MW-1:0]        mode;
        logic signed [VW-1:0] data;
        logic signed [VW-1:0] pri;
        logic                 literal;
        t_queue_reply         reply;
    } t_op_row;

    localparam t_queue_reply NO_REPLY = '0;
    localparam logic signed [VW-1:0] PRI_MIN = 32'sh8000_0000;
    localparam logic signed [VW-1:0] PRI_MAX = 32'sh7FFF_FFFF;

    localparam t_op_row DIRECTED_OPS [DIRECTED_ROWS] = '{
        '{spq_pkg::MODE_DELETE, 32'h0, 32'h0, 1'b1,
          '{spq_pkg::ST_EMPTY, 32'h0, 32'h0, 1'b1, 11'd0}},
        '{spq_pkg::MODE_QUERY, 32'h0, 32'h0, 1'b1,
          '{spq_pkg::ST_OK, 32'h0, 32'h0, 1'b1, 11'd0}},
        '{MODE_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{spq_pkg::ST_OK, 32'h0, 32'h0, 1'b1, 11'd0}},
        '{spq_pkg::MODE_INSERT, PRI_MAX, PRI_MIN, 1'b1,
          '{spq_pkg::ST_OK, 32'h0, 32'h0, 1'b0, 11'd1}},
        '{spq_pkg::MODE_INSERT, PRI_MIN, PRI_MAX, 1'b1,
          '{spq_pkg::ST_OK, 32'h0, 32'h0, 1'b0, 11'd2}},
        // Three equal priorities must come back in arrival order.
        '{spq_pkg::MODE_INSERT, 32'd0, 32'sd5, 1'b0, NO_REPLY},
        '{spq_pkg::MODE_INSERT, 32'd1, 32'sd5, 1'b0, NO_REPLY},
        '{spq_pkg::MODE_INSERT, 32'd2, 32'sd5, 1'b0, NO_REPLY},
        '{spq_pkg::MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, NO_REPLY},
        '{spq_pkg::MODE_INSERT, 32'h1234_5678, 32'h0, 1'b0, NO_REPLY},
        '{spq_pkg::MODE_INSERT, 32'hAAAA_AAAA, PRI_MAX, 1'b0, NO_REPLY},
        '{spq_pkg::MODE_INSERT, 32'h5555_5555, PRI_MIN, 1'b0, NO_REPLY},
        '{spq_pkg::MODE_QUERY, 32'h0, 32'h0, 1'b0, NO_REPLY},
        '{MODE_SPARE, 32'h0, 32'h0, 1'b0, NO_REPLY},
        '{spq_pkg::MODE_DELETE, 32'h0, 32'h0, 1'b1,
          '{spq_pkg::ST_OK, PRI_MIN, PRI_MAX, 1'b0, 11'd8}},
        '{spq_pkg::MODE_DELETE, 32'h0, 32'h0, 1'b0, NO_REPLY},
        '{spq_pkg::MODE_DELETE, 32'h0, 32'h0, 1'b0, NO_REPLY},
        '{spq_pkg::MODE_DELETE, 32'h0, 32'h0, 1'b0, NO_REPLY},
        '{spq_pkg::MODE_DELETE, 32'h0, 32'h0, 1'b0, NO_REPLY},
        '{spq_pkg::MODE_DELETE, 32'h0, 32'h0, 1'b0, NO_REPLY},
        '{spq_pkg::MODE_DELETE, 32'h0, 32'h0, 1'b0, NO_REPLY},
        '{spq_pkg::MODE_DELETE, 32'h0, 32'h0, 1'b0, NO_REPLY},
        '{spq_pkg::MODE_DELETE, 32'h0, 32'h0, 1'b0, NO_REPLY},
        '{spq_pkg::MODE_DELETE, 32'h0, 32'h0, 1'b1,
          '{spq_pkg::ST_EMPTY, 32'h0, 32'h0, 1'b1, 11'd0}},
        '{spq_pkg::MODE_QUERY, 32'h0, 32'h0, 1'b1,
          '{spq_pkg::ST_OK, 32'h0, 32'h0, 1'b1, 11'd0}}
    };

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [spq_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [spq_pkg::OUT_DATA_W-1:0] m_tdata;

    // Model of the queue contents, slot 0 is the head.
    logic signed [VW-1:0] model_payload [spq_pkg::QUEUE_DEPTH];
    logic signed [VW-1:0] model_priority [spq_pkg::QUEUE_DEPTH];
    int                   model_live = 0;

    t_queue_reply pending_replies [$];
    int           mismatch_count = 0;
    int           send_idle_pct = 25;
    int           recv_idle_pct = 69;

    sorted_priority_queue_unit uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Applies one operation to the queue model and returns the reply it gives.
    function automatic t_queue_reply apply_queue_op(input logic [MW-1:0] mode,
                                                    input logic signed [VW-1:0] data,
                                                    input logic signed [VW-1:0] pri);
        t_queue_reply reply;
        int           pos;
        reply = '0;
        reply.status = spq_pkg::ST_OK;
        if (mode == spq_pkg::MODE_INSERT) begin
            if (model_live >= spq_pkg::QUEUE_DEPTH) begin
                reply.status = spq_pkg::ST_FULL;
            end else begin
                // New entry lands behind every entry of equal or higher priority.
                pos = 0;
                while (pos < model_live && model_priority[pos] >= pri) pos++;
                for (int k = model_live; k > pos; k--) begin
                    model_payload[k] = model_payload[k-1];
                    model_priority[k] = model_priority[k-1];
                end
                model_payload[pos] = data;
                model_priority[pos] = pri;
                model_live++;
            end
        end else if (mode == spq_pkg::MODE_DELETE) begin
            if (model_live == 0) begin
                reply.status = spq_pkg::ST_EMPTY;
            end else begin
                reply.rdata = model_payload[0];
                reply.rpri = model_priority[0];
                for (int k = 1; k < model_live; k++) begin
                    model_payload[k-1] = model_payload[k];
                    model_priority[k-1] = model_priority[k];
                end
                model_live--;
            end
        end
        reply.empty = (model_live == 0);
        reply.count = model_live[spq_pkg::OCOUNT_W-1:0];
        return reply;
    endfunction

    // Priorities are drawn so that ties and the signed extremes come up often.
    function automatic logic signed [VW-1:0] pick_priority();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            case ($urandom_range(0, 3))
                0: return PRI_MIN;
                1: return PRI_MAX;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end else if (roll < 50) begin
            return int'($urandom_range(0, 15)) - 8;
        end
        return $urandom;
    endfunction

    // Presents one word after a random idle gap and returns at the edge that
    // accepts it, with the model already advanced.
    task automatic send_op(input logic [MW-1:0] mode,
                           input logic signed [VW-1:0] data,
                           input logic signed [VW-1:0] pri,
                           output t_queue_reply reply);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(spq_pkg::IN_DATA_W - MW - 2 * VW){1'b0}}, pri, data, mode};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        reply = apply_queue_op(mode, data, pri);
    endtask

    task automatic wait_for_replies();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [VW-1:0] want,
                               input logic [VW-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk) begin : result_monitor
        t_queue_reply want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, m_tdata);
                mismatch_count++;
            end else begin
                want = pending_replies.pop_front();
                check_field("status", VW'(want.status), VW'(m_tdata[1:0]));
                check_field("removed_data", want.rdata, m_tdata[33:2]);
                check_field("removed_priority", want.rpri, m_tdata[65:34]);
                check_field("is_empty", VW'(want.empty), VW'(m_tdata[66]));
                check_field("entry_count", VW'(want.count), VW'(m_tdata[77:67]));
            end
        end
    end

    initial begin
        t_queue_reply  reply;
        logic [MW-1:0] mode;
        int            roll;
        int            edge_dwell;
        bit            filling;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_OPS[i]) begin
            send_op(DIRECTED_OPS[i].mode, DIRECTED_OPS[i].data, DIRECTED_OPS[i].pri, reply);
            pending_replies.push_back(DIRECTED_OPS[i].literal ? DIRECTED_OPS[i].reply : reply);
        end
        wait_for_replies();

        // Random traffic swings between filling the queue until inserts bounce
        // off a full queue and draining it until deletes find it empty.
        filling = 1'b1;
        edge_dwell = 0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 3) begin
                wait_for_replies();
                send_idle_pct = 69;
                recv_idle_pct = 25;
            end else if (n == 2 * RANDOM_WORDS / 3) begin
                wait_for_replies();
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            roll = $urandom_range(0, 99);
            if (roll < 88) begin
                mode = filling ? spq_pkg::MODE_INSERT : spq_pkg::MODE_DELETE;
            end else if (roll < 96) begin
                mode = filling ? spq_pkg::MODE_DELETE : spq_pkg::MODE_INSERT;
            end else if (roll < 98) begin
                mode = spq_pkg::MODE_QUERY;
            end else begin
                mode = MODE_SPARE;
            end
            send_op(mode, $urandom, pick_priority(), reply);
            pending_replies.push_back(reply);
            if (model_live == (filling ? spq_pkg::QUEUE_DEPTH : 0)) edge_dwell++;
            if (edge_dwell >= EDGE_DWELL) begin
                filling = !filling;
                edge_dwell = 0;
            end
        end

        wait_for_replies();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("sorted_priority_queue_unit verification clean");
        end else begin
            $display("sorted_priority_queue_unit verification failed");
        end
        $finish;
    end

    initial begin
        #400_000;
        $display("sorted_priority_queue_unit verification failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_unit.sv
dv/tb_top.sv
